### rtl/sn2f_pkg.sv
// Shared types, constants and helpers for the fractal 2D simplex noise block.
// No dependencies; sn2f_front, sn2f_back and the top level import this package.
package sn2f_pkg;

  // Default values of the top-level parameters
  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 18;
  localparam int OCT_CFG_W = 4;
  localparam int PERS_W    = 16;

  // Permutation table
  localparam int PERM_DEPTH = 256;
  localparam int PERM_W     = 8;

  // Shuffle generator
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] LCG_MASK = 32'h7FFF_FFFF;

  // Simplex constants, Q1.16 (NOISE_SCALE is a plain integer)
  localparam int SKEW_Q16    = 23987;
  localparam int UNSKEW_Q16  = 13849;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;
  localparam int NOISE_SCALE = 70;
  localparam int AMP_INIT    = 65536;

  // Output saturation
  localparam int OUT_MAX     = 131071;
  localparam int OUT_MIN_MAG = 131072;

  // Configuration registers
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERSISTENCE  = 1'd1;

  // Register reset values
  localparam logic [OCT_CFG_W-1:0] OCTAVE_COUNT_RST = 4'd4;
  localparam logic [PERS_W-1:0]    PERSISTENCE_RST  = 16'd32768;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_RESEED = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Classified item: arg_a is the seed for a reseed, x for a sample
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] arg_a;
    logic [COORD_W-1:0] arg_b;
  } item_t;

  // Corner gradient from the low three hash bits
  function automatic logic signed [18:0] grad_of(input logic [2:0] h,
                                                 input logic signed [17:0] dx,
                                                 input logic signed [17:0] dy);
    logic signed [18:0] u;
    logic signed [18:0] v;
    logic signed [18:0] a;
    logic signed [18:0] b;
    u = h[2] ? 19'(dy) : 19'(dx);
    v = h[2] ? 19'(dx) : 19'(dy);
    a = h[0] ? -u : u;
    b = h[1] ? -v : v;
    return a + b;
  endfunction

endpackage

### rtl/sn2f_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sn2f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sn2f_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by the shuffle modulo and the final normalization.
module sn2f_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (cnt != '0) begin
      quot <= {quot[NUM_W-2:0], ge};
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

### rtl/sn2f_front.sv
// Front end: accepts request items, classifies them and queues them.
// Depends on sn2f_pkg.
module sn2f_front
  import sn2f_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               op,
  input  logic [COORD_W-1:0] seed,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  output item_t              item,
  output logic               item_valid,
  input  logic               item_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot [QUEUE_DEPTH];
  item_t            new_item;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign req_stall  = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign item_valid = (count != '0);
  assign item       = slot[rd_ptr];

  // Classify: keep only the operands the operation needs
  always_comb begin
    new_item.op = op_t'(op);
    if (op_t'(op) == OP_SAMPLE) begin
      new_item.arg_a = x_coord;
      new_item.arg_b = y_coord;
    end else begin
      new_item.arg_a = seed;
      new_item.arg_b = '0;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !item_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && item_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_item;
    end
  end

endmodule

### rtl/sn2f_back.sv
// Back end: sequencer that rebuilds the permutation table or evaluates
// fractal simplex noise with one shared multiplier. Depends on sn2f_pkg,
// sn2f_ram and sn2f_div.
module sn2f_back
  import sn2f_pkg::*;
#(
  parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 item_valid,
  output logic                 item_pop,
  input  logic [OCT_CFG_W-1:0] octave_count,
  input  logic [PERS_W-1:0]    persistence,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [OUT_W-1:0]     noise_value
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int SKW_W  = F + 24;
  localparam int A_W    = SKW_W + 1;
  localparam int B_W    = 18;
  localparam int P_W    = A_W + B_W;
  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W  = 39 + OCT_W;
  localparam int MAXV_W = 17 + OCT_W;
  localparam int PA_W   = $clog2(PERM_DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE, ST_R_FILL, ST_R_LCG, ST_R_MOD, ST_R_MODW, ST_R_RDI, ST_R_RDJ,
    ST_R_WRI, ST_R_WRJ, ST_SKEW, ST_FRAC, ST_UNSKEW, ST_OFFS, ST_HASH0,
    ST_HASH1, ST_HASH2, ST_HASH3, ST_C_SQX, ST_C_SQY, ST_C_T, ST_C_T2,
    ST_C_T4, ST_C_GR, ST_C_ACC, ST_N_SCALE, ST_N_AMP, ST_N_ACC, ST_N_NEXT,
    ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_t;

  state_t state;

  // Shuffle state
  logic [31:0]     lcg;
  logic [31:0]     lcg_next;
  logic [PA_W-1:0] fill_idx;
  logic [PA_W-1:0] sh_i;
  logic [PA_W-1:0] sh_j;
  logic [PERM_W-1:0] sh_pi;

  // Sample state
  logic signed [COORD_W-1:0] x_lat;
  logic signed [COORD_W-1:0] y_lat;
  logic [SKW_W-1:0]  px;
  logic [SKW_W-1:0]  py;
  logic [OCT_W-1:0]  oct;
  logic [OCT_W-1:0]  oct_inc;
  logic [OCT_W-1:0]  oct_n;
  logic [OCT_W-1:0]  oct_req;
  logic [7:0]        ci;
  logic [7:0]        cj;
  logic [7:0]        pa;
  logic [7:0]        pc;
  logic [7:0]        hash0;
  logic [7:0]        hash1;
  logic [7:0]        hash2;
  logic [15:0]       fx;
  logic [15:0]       fy;
  logic signed [17:0] x0;
  logic signed [17:0] y0;
  logic [1:0]        cidx;
  logic [34:0]       sq;
  logic [15:0]       t;
  logic signed [31:0] sum;
  logic signed [TOT_W-1:0] total;
  logic [MAXV_W-1:0] maxv;
  logic [16:0]       amp;
  logic [OUT_W-1:0]  res_hold;

  // Shared multiplier
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;

  // Combinational helpers
  logic [SKW_W-1:0]   skew_sum;
  logic [SKW_W-1:0]   skew_s;
  logic [SKW_W-1:0]   sx;
  logic [SKW_W-1:0]   sy;
  logic [15:0]        fx_q16;
  logic [15:0]        fy_q16;
  logic [15:0]        un;
  logic               i1;
  logic signed [18:0] x1w;
  logic signed [18:0] y1w;
  logic signed [18:0] x2w;
  logic signed [18:0] y2w;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [7:0]         hsel;
  logic signed [18:0] grad;
  logic [34:0]        sq_tot;
  logic signed [19:0] t_val;
  logic [17:0]        t2;
  logic signed [23:0] noise;
  logic [TOT_W-1:0]   tot_abs;
  logic               tot_neg;
  logic [OUT_W-1:0]   res_sat;

  // RAM and divider hookup
  logic              ram_we;
  logic [PA_W-1:0]   ram_waddr;
  logic [PERM_W-1:0] ram_wdata;
  logic [PA_W-1:0]   ram_raddr;
  logic [PERM_W-1:0] ram_rdata;
  logic              div_start;
  logic [TOT_W-1:0]  div_num;
  logic [MAXV_W-1:0] div_den;
  logic              div_done;
  logic [TOT_W-1:0]  div_quot;
  logic [MAXV_W-1:0] div_rem;

  sn2f_ram #(
    .WIDTH(PERM_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sn2f_div #(
    .NUM_W(TOT_W),
    .DEN_W(MAXV_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign item_pop = (state == ST_IDLE) && item_valid;
  assign lcg_next = (lcg * LCG_MUL + LCG_INC) & LCG_MASK;

  // Octave count clamped to the supported maximum
  assign oct_req = (32'(octave_count) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                     : OCT_W'(octave_count);
  assign oct_inc = oct + OCT_W'(1);

  // Skewed cell and fraction
  assign skew_sum = px + py;
  assign skew_s   = prod[SKW_W+15:16];
  assign sx       = px + skew_s;
  assign sy       = py + skew_s;

  generate
    if (F >= 16) begin : g_frac_down
      assign fx_q16 = sx[F-1:F-16];
      assign fy_q16 = sy[F-1:F-16];
    end else begin : g_frac_up
      assign fx_q16 = {sx[F-1:0], {(16-F){1'b0}}};
      assign fy_q16 = {sy[F-1:0], {(16-F){1'b0}}};
    end
  endgenerate

  // Corner offsets
  assign un  = prod[31:16];
  assign i1  = (x0 > y0);
  assign x1w = 19'(x0) + 19'(UNSKEW_Q16) - (i1 ? 19'(ONE_Q16) : 19'sd0);
  assign y1w = 19'(y0) + 19'(UNSKEW_Q16) - (i1 ? 19'sd0 : 19'(ONE_Q16));
  assign x2w = 19'(x0) + 19'(2 * UNSKEW_Q16) - 19'(ONE_Q16);
  assign y2w = 19'(y0) + 19'(2 * UNSKEW_Q16) - 19'(ONE_Q16);

  always_comb begin
    case (cidx)
      2'd0: begin
        dx   = x0;
        dy   = y0;
        hsel = hash0;
      end
      2'd1: begin
        dx   = 18'(x1w);
        dy   = 18'(y1w);
        hsel = hash1;
      end
      default: begin
        dx   = 18'(x2w);
        dy   = 18'(y2w);
        hsel = hash2;
      end
    endcase
  end

  assign grad   = grad_of(hsel[2:0], dx, dy);
  assign sq_tot = sq + prod[34:0];
  assign t_val  = 20'(HALF_Q16) - 20'({1'b0, sq_tot[34:16]});
  assign t2     = prod[33:16];
  assign noise  = prod[39:16];

  // Normalization operands and saturation
  assign tot_neg = total[TOT_W-1];
  assign tot_abs = tot_neg ? TOT_W'(-total) : TOT_W'(total);

  always_comb begin
    if (!tot_neg && div_quot > TOT_W'(OUT_MAX)) begin
      res_sat = OUT_W'(OUT_MAX);
    end else if (tot_neg && div_quot > TOT_W'(OUT_MIN_MAG)) begin
      res_sat = OUT_W'(-OUT_MIN_MAG);
    end else if (tot_neg) begin
      res_sat = OUT_W'(TOT_W'(0) - div_quot);
    end else begin
      res_sat = OUT_W'(div_quot);
    end
  end

  // Divider sharing: shuffle modulo or final normalization
  assign div_start = (state == ST_R_MOD) || ((state == ST_DIV_START) && (maxv != '0));
  assign div_num   = (state == ST_R_MOD) ? TOT_W'(lcg[30:0]) : tot_abs;
  assign div_den   = (state == ST_R_MOD) ? MAXV_W'({1'b0, sh_i} + 9'd1) : maxv;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SKEW: begin
        mul_a = $signed({1'b0, skew_sum});
        mul_b = B_W'(SKEW_Q16);
      end
      ST_UNSKEW: begin
        mul_a = A_W'($signed({2'b00, fx} + {2'b00, fy}));
        mul_b = B_W'(UNSKEW_Q16);
      end
      ST_C_SQX: begin
        mul_a = A_W'(dx);
        mul_b = dx;
      end
      ST_C_SQY: begin
        mul_a = A_W'(dy);
        mul_b = dy;
      end
      ST_C_T2: begin
        mul_a = A_W'($signed({2'b00, t}));
        mul_b = $signed({2'b00, t});
      end
      ST_C_T4: begin
        mul_a = A_W'($signed(t2));
        mul_b = $signed(t2);
      end
      ST_C_GR: begin
        mul_a = A_W'(grad);
        mul_b = $signed(t2);
      end
      ST_N_SCALE: begin
        mul_a = A_W'(sum);
        mul_b = B_W'(NOISE_SCALE);
      end
      ST_N_AMP: begin
        mul_a = A_W'(noise);
        mul_b = $signed({1'b0, amp});
      end
      ST_N_ACC: begin
        mul_a = A_W'($signed({1'b0, amp}));
        mul_b = $signed({2'b00, persistence});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= P_W'(mul_a) * P_W'(mul_b);
  end

  // RAM port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      ST_R_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx;
        ram_wdata = fill_idx;
      end
      ST_R_RDI:   ram_raddr = sh_i;
      ST_R_RDJ:   ram_raddr = sh_j;
      ST_R_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = sh_i;
        ram_wdata = ram_rdata;
      end
      ST_R_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = sh_j;
        ram_wdata = sh_pi;
      end
      ST_UNSKEW:  ram_raddr = cj;
      ST_OFFS:    ram_raddr = cj + 8'd1;
      ST_HASH0:   ram_raddr = ci + pa;
      ST_HASH1:   ram_raddr = ci + {7'd0, i1} + (i1 ? pa : pc);
      ST_HASH2:   ram_raddr = ci + 8'd1 + pc;
      default:    ram_raddr = '0;
    endcase
  end

  // Sequencer: state, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_R_FILL;
      lcg       <= '0;
      fill_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      // Drop the result once transferred; the output state reloads it itself
      if (res_valid && !res_stall && (state != ST_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.op == OP_RESEED) begin
              lcg      <= item.arg_a;
              fill_idx <= '0;
              state    <= ST_R_FILL;
            end else begin
              x_lat <= $signed(item.arg_a);
              y_lat <= $signed(item.arg_b);
              px    <= SKW_W'($signed(item.arg_a));
              py    <= SKW_W'($signed(item.arg_b));
              oct   <= '0;
              oct_n <= oct_req;
              total <= '0;
              maxv  <= '0;
              amp   <= 17'(AMP_INIT);
              state <= (oct_req == '0) ? ST_DIV_START : ST_SKEW;
            end
          end
        end
        // Table rebuild
        ST_R_FILL: begin
          fill_idx <= fill_idx + PA_W'(1);
          if (fill_idx == PA_W'(PERM_DEPTH - 1)) begin
            sh_i  <= PA_W'(PERM_DEPTH - 1);
            state <= ST_R_LCG;
          end
        end
        ST_R_LCG: begin
          lcg   <= lcg_next;
          state <= ST_R_MOD;
        end
        ST_R_MOD:  state <= ST_R_MODW;
        ST_R_MODW: begin
          if (div_done) begin
            sh_j  <= div_rem[PA_W-1:0];
            state <= ST_R_RDI;
          end
        end
        ST_R_RDI:  state <= ST_R_RDJ;
        ST_R_RDJ: begin
          sh_pi <= ram_rdata;
          state <= ST_R_WRI;
        end
        ST_R_WRI:  state <= ST_R_WRJ;
        ST_R_WRJ: begin
          if (sh_i == PA_W'(1)) begin
            state <= ST_IDLE;
          end else begin
            sh_i  <= sh_i - PA_W'(1);
            state <= ST_R_LCG;
          end
        end
        // Cell and fraction of one octave
        ST_SKEW:   state <= ST_FRAC;
        ST_FRAC: begin
          ci    <= sx[F+7:F];
          cj    <= sy[F+7:F];
          fx    <= fx_q16;
          fy    <= fy_q16;
          state <= ST_UNSKEW;
        end
        ST_UNSKEW: state <= ST_OFFS;
        ST_OFFS: begin
          x0    <= $signed({2'b00, fx}) - $signed({2'b00, un});
          y0    <= $signed({2'b00, fy}) - $signed({2'b00, un});
          pa    <= ram_rdata;
          state <= ST_HASH0;
        end
        ST_HASH0: begin
          pc    <= ram_rdata;
          state <= ST_HASH1;
        end
        ST_HASH1: begin
          hash0 <= ram_rdata;
          state <= ST_HASH2;
        end
        ST_HASH2: begin
          hash1 <= ram_rdata;
          state <= ST_HASH3;
        end
        ST_HASH3: begin
          hash2 <= ram_rdata;
          cidx  <= 2'd0;
          sum   <= '0;
          state <= ST_C_SQX;
        end
        // Corner contributions
        ST_C_SQX:  state <= ST_C_SQY;
        ST_C_SQY: begin
          sq    <= prod[34:0];
          state <= ST_C_T;
        end
        ST_C_T: begin
          t <= t_val[15:0];
          if (t_val[19]) begin
            if (cidx == 2'd2) begin
              state <= ST_N_SCALE;
            end else begin
              cidx  <= cidx + 2'd1;
              state <= ST_C_SQX;
            end
          end else begin
            state <= ST_C_T2;
          end
        end
        ST_C_T2:   state <= ST_C_T4;
        ST_C_T4:   state <= ST_C_GR;
        ST_C_GR:   state <= ST_C_ACC;
        ST_C_ACC: begin
          sum <= sum + 32'(prod);
          if (cidx == 2'd2) begin
            state <= ST_N_SCALE;
          end else begin
            cidx  <= cidx + 2'd1;
            state <= ST_C_SQX;
          end
        end
        // Octave accumulation
        ST_N_SCALE: state <= ST_N_AMP;
        ST_N_AMP:   state <= ST_N_ACC;
        ST_N_ACC: begin
          total <= total + TOT_W'(prod);
          maxv  <= maxv + MAXV_W'(amp);
          state <= ST_N_NEXT;
        end
        ST_N_NEXT: begin
          amp <= prod[32:16];
          oct <= oct_inc;
          px  <= SKW_W'(x_lat) << oct_inc;
          py  <= SKW_W'(y_lat) << oct_inc;
          state <= (oct_inc == oct_n) ? ST_DIV_START : ST_SKEW;
        end
        // Normalize and saturate
        ST_DIV_START: begin
          if (maxv == '0) begin
            res_hold <= '0;
            state    <= ST_OUT;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_hold <= res_sat;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid   <= 1'b1;
            noise_value <= res_hold;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/simplex_noise_2d_fractal.sv
// Fractal 2D simplex noise. A sample runs, per octave, a shared-multiplier
// sequence (setup, the three corners, accumulation) and then a bit-serial
// normalizing divide; a reseed fills the table, then swaps each entry from the
// top down, each swap using an LCG step and a modulo on the shared divider.
// After reset the table is built from seed zero by the same sequence; items are
// queued meanwhile. Registers reset to four octaves and persistence one half.
module simplex_noise_2d_fractal
  import sn2f_pkg::*;
#(
  parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 op,
  input  logic [COORD_W-1:0]   seed,
  input  logic [COORD_W-1:0]   x_coord,
  input  logic [COORD_W-1:0]   y_coord,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [OUT_W-1:0]     noise_value,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [PERS_W-1:0]    wr_data
);

  logic [OCT_CFG_W-1:0] octave_count;
  logic [PERS_W-1:0]    persistence;
  item_t                item;
  logic                 item_valid;
  logic                 item_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCTAVE_COUNT_RST;
      persistence  <= PERSISTENCE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OCTAVE_COUNT: octave_count <= wr_data[OCT_CFG_W-1:0];
        REG_PERSISTENCE:  persistence  <= wr_data;
        default:          octave_count <= octave_count;
      endcase
    end
  end

  sn2f_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .seed      (seed),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .item      (item),
    .item_valid(item_valid),
    .item_pop  (item_pop)
  );

  sn2f_back #(
    .MAX_OCTAVES    (MAX_OCTAVES),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_valid  (item_valid),
    .item_pop    (item_pop),
    .octave_count(octave_count),
    .persistence (persistence),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .noise_value (noise_value)
  );

endmodule
